// ===== hw/rtl/bat_pkg.sv =====
// Shared types, constants and helpers for the buddy allocator tree unit.
`timescale 1ns / 1ps
`default_nettype none
package bat_pkg;

  localparam int MIN_ORDER_DEF = 6;
  localparam int MAX_ORDER_DEF = 16;
  localparam int REQ_W = 17;
  localparam int OFF_W = 16;

  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_FREE  = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_OOM     = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ROOT,
    S_DL,
    S_DR,
    S_DDEC,
    S_MARK,
    S_AS,
    S_AP,
    S_AWR,
    S_FCHK,
    S_FCLR,
    S_DONE
  } seq_state_t;

  function automatic logic [4:0] ceil_log2_req(input logic [REQ_W-1:0] n);
    logic [4:0] k;
    k = 5'd17;
    for (int i = REQ_W - 1; i >= 0; i--) begin
      if ((18'd1 << i) >= {1'b0, n}) begin
        k = 5'(i);
      end
    end
    return k;
  endfunction

endpackage
`default_nettype wire

// ===== hw/rtl/buddy_allocator_tree_unit.sv =====
// Buddy allocator tree unit: tree memory, clearing sweep and sequencer.
// Allocate of order k: root check, descent down to order k, mark, ancestor refresh.
// Out of memory when the size is rejected or when the root lacks room.
// Free: climb from the leaf to the allocated node, clear it, refresh its ancestors.
// The tree memory port allows one read and one write per cycle.
// After reset a clearing sweep of 2^(MAX_ORDER-MIN_ORDER+1)-1 nodes holds busy high.
// One transaction at a time; the result strobe lasts one cycle and cannot be stalled.
`timescale 1ns / 1ps
`default_nettype none
module buddy_allocator_tree_unit #(
  parameter int MIN_ORDER = bat_pkg::MIN_ORDER_DEF,
  parameter int MAX_ORDER = bat_pkg::MAX_ORDER_DEF
) (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      start,
  output logic                           busy,
  input  wire logic                      in_command,
  input  wire logic [bat_pkg::REQ_W-1:0] in_req_size,
  input  wire logic [bat_pkg::OFF_W-1:0] in_free_offset,
  output logic                           out_valid,
  output logic      [1:0]                out_status,
  output logic      [bat_pkg::OFF_W-1:0] out_block_offset
);

  localparam int LEVELS = MAX_ORDER - MIN_ORDER;
  localparam int AW = LEVELS + 1;
  localparam int NODES = (1 << (LEVELS + 1)) - 1;
  localparam int AVW = $clog2(MAX_ORDER + 2);
  localparam int DW = AVW + 1;

  logic          clr_active_r, clr_active_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  logic [AW-1:0] clr_lvl_r, clr_lvl_nxt;
  logic [AW:0]   clr_bnd_r, clr_bnd_nxt;

  logic          seq_busy;
  logic          accept;
  logic          s_we;
  logic [AW-1:0] s_waddr, s_raddr;
  logic [DW-1:0] s_wdata;
  logic          m_we;
  logic [AW-1:0] m_waddr;
  logic [DW-1:0] m_wdata;
  logic [DW-1:0] m_rdata;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
      clr_lvl_r    <= '0;
      clr_bnd_r    <= '0;
    end else begin
      clr_active_r <= clr_active_nxt;
      clr_addr_r   <= clr_addr_nxt;
      clr_lvl_r    <= clr_lvl_nxt;
      clr_bnd_r    <= clr_bnd_nxt;
    end
  end

  always_comb begin
    clr_active_nxt = clr_active_r;
    clr_addr_nxt   = clr_addr_r;
    clr_lvl_nxt    = clr_lvl_r;
    clr_bnd_nxt    = clr_bnd_r;
    if (clr_active_r) begin
      if (clr_addr_r == AW'(NODES - 1)) begin
        clr_active_nxt = 1'b0;
      end
      clr_addr_nxt = clr_addr_r + AW'(1);
      if ({1'b0, clr_addr_r} == clr_bnd_r) begin
        clr_lvl_nxt = clr_lvl_r + AW'(1);
        clr_bnd_nxt = (clr_bnd_r << 1) + (AW + 1)'(2);
      end
    end
  end

  assign busy   = clr_active_r | seq_busy;
  assign accept = start & ~busy;

  assign m_we    = clr_active_r | s_we;
  assign m_waddr = clr_active_r ? clr_addr_r : s_waddr;
  assign m_wdata = clr_active_r ? {1'b0, AVW'(MAX_ORDER + 1 - int'(clr_lvl_r))} : s_wdata;

  bat_ram #(
    .W (DW),
    .D (NODES)
  ) u_tree (
    .clk   (clk),
    .we    (m_we),
    .waddr (m_waddr),
    .wdata (m_wdata),
    .raddr (s_raddr),
    .rdata (m_rdata)
  );

  bat_seq #(
    .MIN_ORDER (MIN_ORDER),
    .MAX_ORDER (MAX_ORDER)
  ) u_seq (
    .clk              (clk),
    .rst_n            (rst_n),
    .accept           (accept),
    .command          (in_command),
    .req_size         (in_req_size),
    .free_offset      (in_free_offset),
    .seq_busy         (seq_busy),
    .out_valid        (out_valid),
    .out_status       (out_status),
    .out_block_offset (out_block_offset),
    .mem_we           (s_we),
    .mem_waddr        (s_waddr),
    .mem_wdata        (s_wdata),
    .mem_raddr        (s_raddr),
    .mem_rdata        (m_rdata)
  );

`ifndef ASSERT_OFF
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> busy)
    else $error("busy not raised after accepted transaction");

  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_fail_offset_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_status != bat_pkg::ST_DONE) |-> out_block_offset == '0)
    else $error("nonzero offset on failed transaction");

  a_no_clear_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    clr_active_r |-> !s_we)
    else $error("sequencer write during clearing sweep");
`endif

endmodule
`default_nettype wire

// ===== hw/rtl/bat_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module bat_ram #(
  parameter int W = 6,
  parameter int D = 2047
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ===== hw/rtl/bat_seq.sv =====
// Allocate and free sequencer: tree descent, climb and ancestor refresh.
`timescale 1ns / 1ps
`default_nettype none
module bat_seq #(
  parameter int MIN_ORDER = bat_pkg::MIN_ORDER_DEF,
  parameter int MAX_ORDER = bat_pkg::MAX_ORDER_DEF,
  localparam int LEVELS = MAX_ORDER - MIN_ORDER,
  localparam int AW = LEVELS + 1,
  localparam int AVW = $clog2(MAX_ORDER + 2),
  localparam int DW = AVW + 1
) (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     accept,
  input  wire logic                     command,
  input  wire logic [bat_pkg::REQ_W-1:0] req_size,
  input  wire logic [bat_pkg::OFF_W-1:0] free_offset,
  output logic                          seq_busy,
  output logic                          out_valid,
  output logic      [1:0]               out_status,
  output logic      [bat_pkg::OFF_W-1:0] out_block_offset,
  output logic                          mem_we,
  output logic      [AW-1:0]            mem_waddr,
  output logic      [DW-1:0]            mem_wdata,
  output logic      [AW-1:0]            mem_raddr,
  input  wire logic [DW-1:0]            mem_rdata
);

  localparam int FIRST_LEAF = (1 << LEVELS) - 1;

  bat_pkg::seq_state_t state_r, state_nxt;
  logic [AW-1:0]  idx_r, idx_nxt;
  logic [AVW-1:0] ord_r, ord_nxt;
  logic [AVW-1:0] layer_r, layer_nxt;
  logic [AVW-1:0] cur_r, cur_nxt;
  logic [AVW-1:0] sib_r, sib_nxt;
  logic [AVW-1:0] lav_r, lav_nxt;
  logic [DW-1:0]  lw_r, lw_nxt;
  logic [DW-1:0]  nword_r, nword_nxt;
  logic           merge_r, merge_nxt;
  bat_pkg::status_t status_r, status_nxt;
  logic [bat_pkg::OFF_W-1:0] off_r, off_nxt;

  logic [4:0]     raw_layer;
  logic [AVW-1:0] need;
  logic [AVW-1:0] rd_av;
  logic [AVW-1:0] ord_up;
  logic [AVW-1:0] new_av;
  logic [AW-1:0]  li, ri, parent, sib_addr;
  logic [31:0]    off_full;
  logic [31:0]    offw;

  function automatic logic [AVW-1:0] avail_of(input logic [DW-1:0] w);
    return w[DW-1] ? '0 : w[AVW-1:0];
  endfunction

  assign raw_layer = bat_pkg::ceil_log2_req(req_size);
  assign need      = layer_r + AVW'(1);
  assign rd_av     = avail_of(mem_rdata);
  assign ord_up    = ord_r + AVW'(1);
  assign li        = AW'({idx_r, 1'b1});
  assign ri        = li + AW'(1);
  assign parent    = AW'((idx_r - AW'(1)) >> 1);
  assign sib_addr  = idx_r[0] ? idx_r + AW'(1) : idx_r - AW'(1);
  assign offw      = 32'(free_offset);
  assign off_full  = (32'(idx_r) - ((32'd1 << (MAX_ORDER - int'(layer_r))) - 32'd1))
                     << layer_r;
  assign new_av    = (merge_r && cur_r == ord_up && sib_r == ord_up) ? ord_up + AVW'(1) :
                     ((cur_r > sib_r) ? cur_r : sib_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= bat_pkg::S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    ord_r    <= ord_nxt;
    layer_r  <= layer_nxt;
    cur_r    <= cur_nxt;
    sib_r    <= sib_nxt;
    lav_r    <= lav_nxt;
    lw_r     <= lw_nxt;
    nword_r  <= nword_nxt;
    merge_r  <= merge_nxt;
    status_r <= status_nxt;
    off_r    <= off_nxt;
  end

  always_comb begin
    logic [AVW-1:0] l_av;
    logic [AVW-1:0] r_av;
    logic           pick_left;
    logic [AVW-1:0] p_av;
    state_nxt  = state_r;
    idx_nxt    = idx_r;
    ord_nxt    = ord_r;
    layer_nxt  = layer_r;
    cur_nxt    = cur_r;
    sib_nxt    = sib_r;
    lav_nxt    = lav_r;
    lw_nxt     = lw_r;
    nword_nxt  = nword_r;
    merge_nxt  = merge_r;
    status_nxt = status_r;
    off_nxt    = off_r;
    mem_we     = 1'b0;
    mem_waddr  = idx_r;
    mem_wdata  = nword_r;
    mem_raddr  = idx_r;
    out_valid  = 1'b0;
    l_av       = lav_r;
    r_av       = rd_av;
    pick_left  = 1'b0;
    p_av       = '0;

    case (state_r)
      bat_pkg::S_IDLE: begin
        if (accept) begin
          off_nxt    = '0;
          status_nxt = bat_pkg::ST_DONE;
          if (command == bat_pkg::CMD_ALLOC) begin
            if (req_size == '0 || int'(raw_layer) > MAX_ORDER) begin
              status_nxt = bat_pkg::ST_OOM;
              state_nxt  = bat_pkg::S_DONE;
            end else begin
              layer_nxt = (int'(raw_layer) < MIN_ORDER) ? AVW'(MIN_ORDER) : AVW'(raw_layer);
              mem_raddr = '0;
              state_nxt = bat_pkg::S_ROOT;
            end
          end else begin
            if ((offw >> MAX_ORDER) != 32'd0) begin
              status_nxt = bat_pkg::ST_IGNORED;
              state_nxt  = bat_pkg::S_DONE;
            end else begin
              idx_nxt   = AW'(offw >> MIN_ORDER) + AW'(FIRST_LEAF);
              mem_raddr = idx_nxt;
              ord_nxt   = AVW'(MIN_ORDER);
              state_nxt = bat_pkg::S_FCHK;
            end
          end
        end
      end
      bat_pkg::S_ROOT: begin
        if (rd_av < need) begin
          status_nxt = bat_pkg::ST_OOM;
          state_nxt  = bat_pkg::S_DONE;
        end else begin
          idx_nxt   = '0;
          ord_nxt   = AVW'(MAX_ORDER);
          nword_nxt = mem_rdata;
          state_nxt = (AVW'(MAX_ORDER) == layer_r) ? bat_pkg::S_MARK : bat_pkg::S_DL;
        end
      end
      bat_pkg::S_DL: begin
        mem_raddr = li;
        state_nxt = bat_pkg::S_DR;
      end
      bat_pkg::S_DR: begin
        lav_nxt   = rd_av;
        lw_nxt    = mem_rdata;
        mem_raddr = ri;
        state_nxt = bat_pkg::S_DDEC;
      end
      bat_pkg::S_DDEC: begin
        if (l_av <= r_av) begin
          pick_left = (l_av >= need);
        end else begin
          pick_left = !(r_av >= need);
        end
        p_av = pick_left ? l_av : r_av;
        if (p_av >= need) begin
          idx_nxt   = pick_left ? li : ri;
          nword_nxt = pick_left ? lw_r : mem_rdata;
        end
        ord_nxt   = ord_r - AVW'(1);
        state_nxt = (ord_nxt == layer_r) ? bat_pkg::S_MARK : bat_pkg::S_DL;
      end
      bat_pkg::S_MARK: begin
        mem_we     = 1'b1;
        mem_waddr  = idx_r;
        mem_wdata  = {1'b1, nword_r[AVW-1:0]};
        off_nxt    = off_full[bat_pkg::OFF_W-1:0];
        cur_nxt    = '0;
        merge_nxt  = 1'b0;
        status_nxt = bat_pkg::ST_DONE;
        state_nxt  = (idx_r == '0) ? bat_pkg::S_DONE : bat_pkg::S_AS;
      end
      bat_pkg::S_AS: begin
        mem_raddr = sib_addr;
        state_nxt = bat_pkg::S_AP;
      end
      bat_pkg::S_AP: begin
        sib_nxt   = rd_av;
        mem_raddr = parent;
        state_nxt = bat_pkg::S_AWR;
      end
      bat_pkg::S_AWR: begin
        mem_we    = 1'b1;
        mem_waddr = parent;
        mem_wdata = {mem_rdata[DW-1], new_av};
        cur_nxt   = mem_rdata[DW-1] ? '0 : new_av;
        idx_nxt   = parent;
        ord_nxt   = ord_up;
        state_nxt = (parent == '0) ? bat_pkg::S_DONE : bat_pkg::S_AS;
      end
      bat_pkg::S_FCHK: begin
        if (mem_rdata[DW-1]) begin
          state_nxt = bat_pkg::S_FCLR;
        end else if (idx_r == '0) begin
          status_nxt = bat_pkg::ST_IGNORED;
          state_nxt  = bat_pkg::S_DONE;
        end else begin
          idx_nxt   = parent;
          ord_nxt   = ord_up;
          mem_raddr = parent;
        end
      end
      bat_pkg::S_FCLR: begin
        mem_we     = 1'b1;
        mem_waddr  = idx_r;
        mem_wdata  = {1'b0, ord_up};
        cur_nxt    = ord_up;
        merge_nxt  = 1'b1;
        status_nxt = bat_pkg::ST_DONE;
        state_nxt  = (idx_r == '0) ? bat_pkg::S_DONE : bat_pkg::S_AS;
      end
      bat_pkg::S_DONE: begin
        out_valid = 1'b1;
        state_nxt = bat_pkg::S_IDLE;
      end
      default: begin
        state_nxt = bat_pkg::S_IDLE;
      end
    endcase
  end

  assign seq_busy         = (state_r != bat_pkg::S_IDLE);
  assign out_status       = status_r;
  assign out_block_offset = off_r;

endmodule
`default_nettype wire
